// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SMOD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SMOD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/smod_pkg.sv -----
package smod_pkg;

  localparam int MASK_W_DEF = 64;
  localparam int MASK_H_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 12;
  localparam int ALPHA_W = 8;
  localparam int POS_W   = 12;
  localparam int SIZE_W  = 7;
  // screen coordinate plus size
  localparam int CW      = POS_W + 1;
  // row-major index within a clamped sprite
  localparam int IW      = 2 * SIZE_W;
  localparam int ADDR_SPAN = 2 ** ADDR_W;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_MUL_A,
    ST_MUL_B,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } smod_state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SIZE_W-1:0]       width;
    logic [SIZE_W-1:0]       height;
  } smod_sprite_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } smod_status_t;

endpackage

// ----- hw/rtl/smod_mask_ram.sv -----
module smod_mask_ram #(
  parameter int DEPTH = smod_pkg::ADDR_SPAN,
  parameter int AW    = smod_pkg::ADDR_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/smod_scan.sv -----
`include "assert_macros.svh"

module smod_scan #(
  parameter int MASK_W = smod_pkg::MASK_W_DEF,
  parameter int MASK_H = smod_pkg::MASK_H_DEF,
  parameter int AW     = smod_pkg::ADDR_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  smod_pkg::smod_sprite_t a,
  input  smod_pkg::smod_sprite_t b,
  input  logic                 qa,
  input  logic                 qb,
  input  logic                 free,
  output logic [AW-1:0]        ra_addr,
  output logic [AW-1:0]        rb_addr,
  output smod_pkg::smod_status_t st
);

  import smod_pkg::*;

  localparam int SMAX = 2 ** SIZE_W - 1;
  localparam logic [SIZE_W-1:0] WLIM = (MASK_W > SMAX) ? SIZE_W'(SMAX) : SIZE_W'(MASK_W);
  localparam logic [SIZE_W-1:0] HLIM = (MASK_H > SMAX) ? SIZE_W'(SMAX) : SIZE_W'(MASK_H);

  smod_state_t state, state_next;

  logic signed [CW-1:0] ax, ay, bx, by;
  logic [SIZE_W-1:0]    aw, ah, bw, bh;
  logic signed [CW-1:0] x0, x1, y0, y1;
  logic [SIZE_W-1:0]    ncols_m1, nrows_m1, col, row;
  logic [IW-1:0]        ia, ib, rsa, rsb;
  logic                 pend, hit;

  logic signed [CW-1:0] ax_end, bx_end, ay_end, by_end;
  logic                 empty, both;
  logic [SIZE_W-1:0]    mul_x, mul_y, mul_c;
  logic [IW-1:0]        prod, mul_sum;

  assign ax_end = ax + $signed({{(CW-SIZE_W){1'b0}}, aw});
  assign bx_end = bx + $signed({{(CW-SIZE_W){1'b0}}, bw});
  assign ay_end = ay + $signed({{(CW-SIZE_W){1'b0}}, ah});
  assign by_end = by + $signed({{(CW-SIZE_W){1'b0}}, bh});

  assign empty = (x0 >= x1) || (y0 >= y1);
  assign both  = pend && qa && qb;

  // shared multiplier: row offset times stride, plus column offset
  always_comb begin
    if (state == ST_MUL_A) begin
      mul_x = SIZE_W'(y0 - ay);
      mul_y = aw;
      mul_c = SIZE_W'(x0 - ax);
    end else begin
      mul_x = SIZE_W'(y0 - by);
      mul_y = bw;
      mul_c = SIZE_W'(x0 - bx);
    end
  end

  assign prod    = IW'(mul_x) * IW'(mul_y);
  assign mul_sum = prod + IW'(mul_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    st.busy    = (state != ST_IDLE);
    st.done    = 1'b0;
    st.hit     = hit;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_BOX;
      ST_BOX:   state_next = ST_MUL_A;
      ST_MUL_A: state_next = empty ? ST_DONE : ST_MUL_B;
      ST_MUL_B: state_next = ST_SCAN;
      ST_SCAN: begin
        if (both) begin
          state_next = ST_DONE;
        end else if (col == ncols_m1 && row == nrows_m1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        st.done = free;
        if (free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        hit <= 1'b0;
        if (start) begin
          ax <= {a.pos_x[POS_W-1], a.pos_x};
          ay <= {a.pos_y[POS_W-1], a.pos_y};
          bx <= {b.pos_x[POS_W-1], b.pos_x};
          by <= {b.pos_y[POS_W-1], b.pos_y};
          aw <= (a.width  > WLIM) ? WLIM : a.width;
          ah <= (a.height > HLIM) ? HLIM : a.height;
          bw <= (b.width  > WLIM) ? WLIM : b.width;
          bh <= (b.height > HLIM) ? HLIM : b.height;
        end
      end
      ST_BOX: begin
        x0 <= (ax > bx) ? ax : bx;
        y0 <= (ay > by) ? ay : by;
        x1 <= (ax_end < bx_end) ? ax_end : bx_end;
        y1 <= (ay_end < by_end) ? ay_end : by_end;
      end
      ST_MUL_A: begin
        rsa      <= prod;
        ia       <= mul_sum;
        ncols_m1 <= SIZE_W'(x1 - x0 - CW'(1));
        nrows_m1 <= SIZE_W'(y1 - y0 - CW'(1));
        col      <= '0;
        row      <= '0;
      end
      ST_MUL_B: begin
        rsb <= prod;
        ib  <= mul_sum;
      end
      ST_SCAN: begin
        if (both) begin
          hit <= 1'b1;
        end else if (col == ncols_m1) begin
          // advance to the start of the next row
          col <= '0;
          row <= row + SIZE_W'(1);
          rsa <= rsa + IW'(aw);
          rsb <= rsb + IW'(bw);
          ia  <= rsa + IW'(aw) + IW'(x0 - ax);
          ib  <= rsb + IW'(bw) + IW'(x0 - bx);
        end else begin
          col <= col + SIZE_W'(1);
          ia  <= ia + IW'(1);
          ib  <= ib + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (both) hit <= 1'b1;
      end
      default: ;
    endcase
  end

  assign ra_addr = ia[AW-1:0];
  assign rb_addr = ib[AW-1:0];

  `SMOD_ASSERT_IMP(a_done_free, st.done, free, "result finished while output full")
  `SMOD_ASSERT_NXT(a_drain_done, state == ST_DRAIN, state == ST_DONE, "drain did not finish")
  `SMOD_ASSERT_NXT(a_start_box, start && state == ST_IDLE, state == ST_BOX, "check not taken")

endmodule

// ----- hw/rtl/sprite_mask_overlap_detect_core.sv -----
// Channel | Signals                                   | Beat taken when
// in      | in_valid, in_stall, cmd .. b_height       | in_valid && !in_stall
// out     | out_valid, out_stall, hit                 | out_valid && !out_stall
//
// A load beat writes one bit (alpha nonzero) of mask A or B when mask_addr is in range.
// A check beat steps through box, two multiply states, a scan over every pixel of
// the overlap (rows * cols) and a drain, stops early on a hit and goes to done when
// the boxes do not overlap; one pixel pair is read per cycle from the two mask RAMs.
// Reset is synchronous; it clears control state only, mask contents stay undefined.
// in_stall is high while a check runs or its result waits for a free output; a result
// shown under out_stall waits while loads continue.
`include "assert_macros.svh"

module sprite_mask_overlap_detect_core #(
  parameter int MASK_W = smod_pkg::MASK_W_DEF,
  parameter int MASK_H = smod_pkg::MASK_H_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [smod_pkg::CMD_W-1:0]          cmd,
  input  logic [smod_pkg::ADDR_W-1:0]         mask_addr,
  input  logic [smod_pkg::ALPHA_W-1:0]        alpha,
  input  logic signed [smod_pkg::POS_W-1:0]   a_pos_x,
  input  logic signed [smod_pkg::POS_W-1:0]   a_pos_y,
  input  logic [smod_pkg::SIZE_W-1:0]         a_width,
  input  logic [smod_pkg::SIZE_W-1:0]         a_height,
  input  logic signed [smod_pkg::POS_W-1:0]   b_pos_x,
  input  logic signed [smod_pkg::POS_W-1:0]   b_pos_y,
  input  logic [smod_pkg::SIZE_W-1:0]         b_width,
  input  logic [smod_pkg::SIZE_W-1:0]         b_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit
);

  import smod_pkg::*;

  localparam int DEPTH     = MASK_W * MASK_H;
  localparam int MEM_DEPTH = (DEPTH > ADDR_SPAN) ? ADDR_SPAN : DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic          acc, in_range, wbit, free, qa, qb;
  logic          we_a, we_b, start;
  logic [AW-1:0] ra_addr, rb_addr;
  smod_sprite_t  spr_a, spr_b;
  smod_status_t  st;

  assign in_stall = st.busy;
  assign acc      = in_valid && !in_stall;
  assign in_range = (int'(mask_addr) < MEM_DEPTH);
  assign wbit     = (alpha != '0);
  assign we_a     = acc && (cmd == CMD_LOAD_A) && in_range;
  assign we_b     = acc && (cmd == CMD_LOAD_B) && in_range;
  assign start    = acc && (cmd == CMD_CHECK);
  assign free     = !out_valid || !out_stall;

  assign spr_a = '{pos_x: a_pos_x, pos_y: a_pos_y, width: a_width, height: a_height};
  assign spr_b = '{pos_x: b_pos_x, pos_y: b_pos_y, width: b_width, height: b_height};

  smod_mask_ram #(.DEPTH(MEM_DEPTH), .AW(AW)) u_mask_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (mask_addr[AW-1:0]),
    .wdata (wbit),
    .raddr (ra_addr),
    .rdata (qa)
  );

  smod_mask_ram #(.DEPTH(MEM_DEPTH), .AW(AW)) u_mask_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (mask_addr[AW-1:0]),
    .wdata (wbit),
    .raddr (rb_addr),
    .rdata (qb)
  );

  smod_scan #(.MASK_W(MASK_W), .MASK_H(MASK_H), .AW(AW)) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .a       (spr_a),
    .b       (spr_b),
    .qa      (qa),
    .qb      (qb),
    .free    (free),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .st      (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st.done) begin
      hit <= st.hit;
    end
  end

  `SMOD_ASSERT_NXT(a_check_holds, start, in_stall, "intake open during check")
  `SMOD_ASSERT_NXT(a_done_shows, st.done, out_valid, "finished result not shown")
  `SMOD_ASSERT_IMP(a_done_busy, st.done, st.busy, "result from idle scan")

endmodule
